### sv/rc4_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the rc4 keystream cipher
// no dependencies; imported by rc4_ram and rc4_keystream_cipher_top
package rc4_pkg;

    typedef logic [7:0] byte_t;

    // operation codes carried in s_tuser
    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_SCHEDULE = 2'd1;
    localparam logic [1:0] OP_CRYPT    = 2'd2;

    // permutation geometry
    localparam int PERM_AW = 8;
    localparam int PERM_DEPTH = 256;

    // key length register width and reset value
    localparam int KLEN_W = 9;
    localparam logic [KLEN_W-1:0] KLEN_RESET = 9'd16;

endpackage

### sv/rc4_keystream_cipher_top.sv
`timescale 1ns / 1ps
// rc4 keystream cipher top level: key store, permutation ram, sequencer
// depends on rc4_pkg and rc4_ram
// sequencing: a keyed crypt steps through CRDJ, CSWP and CEMIT before its result is registered
//   onto m_tvalid, an unkeyed crypt goes straight to CEMIT; load and unused-opcode transactions
//   finish in the idle state; the single permutation ram port pair serves read S[i], read S[j],
//   read S[t] and two swap writes per keyed crypt; s_tready is high only in idle, so a schedule
//   holds the input through the identity fill of all 256 entries and 256 key steps, and a
//   stalled result holds the next crypt in its emit state
// reset (aresetn low, synchronous): clears indices, keyed flag, output valid and
//   sets key_length to 16; key store and permutation ram are not cleared
module rc4_keystream_cipher_top #(
    parameter int KEY_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: key_length
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] key_index, [15:8] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data_out
    output logic [0:0]  m_tuser    // [0] not_keyed
);
    import rc4_pkg::*;

    localparam int KEY_AW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam logic [KLEN_W-1:0] KEY_LIM = KLEN_W'(KEY_BYTES);

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FILL  = 4'd1;
    localparam logic [3:0] ST_KRDN  = 4'd2;
    localparam logic [3:0] ST_KRDJ  = 4'd3;
    localparam logic [3:0] ST_KWRN  = 4'd4;
    localparam logic [3:0] ST_KWRJ  = 4'd5;
    localparam logic [3:0] ST_CRDJ  = 4'd6;
    localparam logic [3:0] ST_CSWP  = 4'd7;
    localparam logic [3:0] ST_CEMIT = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [KLEN_W-1:0] key_length_reg;
    logic [KLEN_W-1:0] eff_len;
    byte_t             i_reg, i_next;
    byte_t             j_reg, j_next;
    logic              keyed_reg, keyed_next;
    byte_t             n_reg, n_next;
    logic [KEY_AW-1:0] kn_reg, kn_next;
    byte_t             si_reg, si_next;
    byte_t             sj_reg, sj_next;
    byte_t             t_reg, t_next;
    byte_t             data_reg, data_next;
    logic              nk_reg, nk_next;
    logic              m_tvalid_reg, m_tvalid_next;
    byte_t             m_data_reg, m_data_next;
    logic              m_nk_reg, m_nk_next;

    logic              s_accept;
    logic              out_free;
    logic [1:0]        in_op;
    byte_t             in_kidx;
    byte_t             in_data;
    byte_t             ks;

    logic              perm_we;
    byte_t             perm_waddr;
    byte_t             perm_wdata;
    byte_t             perm_raddr;
    byte_t             perm_rdata;

    logic              key_we;
    logic [KEY_AW-1:0] key_waddr;
    logic [KEY_AW-1:0] key_raddr;
    byte_t             key_rdata;

    assign in_op   = s_tuser;
    assign in_kidx = s_tdata[7:0];
    assign in_data = s_tdata[15:8];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_nk_reg;

    // clamp key length into 1 .. KEY_BYTES
    always_comb begin
        if (key_length_reg == '0) begin
            eff_len = KLEN_W'(1);
        end else if (key_length_reg > KEY_LIM) begin
            eff_len = KEY_LIM;
        end else begin
            eff_len = key_length_reg;
        end
    end

    // keystream byte with forwarding of the swapped entries
    always_comb begin
        if (t_reg == j_reg) begin
            ks = si_reg;
        end else if (t_reg == i_reg) begin
            ks = sj_reg;
        end else begin
            ks = perm_rdata;
        end
    end

    // key store: loads write directly, schedule reads at the key counter
    assign key_we    = s_accept && (in_op == OP_LOAD) && ({1'b0, in_kidx} < KEY_LIM);
    assign key_waddr = in_kidx[KEY_AW-1:0];
    assign key_raddr = kn_reg;

    // sequencer next state and memory controls
    always_comb begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        keyed_next    = keyed_reg;
        n_next        = n_reg;
        kn_next       = kn_reg;
        si_next       = si_reg;
        sj_next       = sj_reg;
        t_next        = t_reg;
        data_next     = data_reg;
        nk_next       = nk_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_nk_next     = m_nk_reg;
        perm_we       = 1'b0;
        perm_waddr    = n_reg;
        perm_wdata    = n_reg;
        perm_raddr    = n_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (in_op)
                        OP_SCHEDULE: begin
                            n_next     = '0;
                            state_next = ST_FILL;
                        end
                        OP_CRYPT: begin
                            data_next = in_data;
                            nk_next   = !keyed_reg;
                            if (keyed_reg) begin
                                i_next     = i_reg + 8'd1;
                                perm_raddr = i_reg + 8'd1;
                                state_next = ST_CRDJ;
                            end else begin
                                state_next = ST_CEMIT;
                            end
                        end
                        default: begin
                            // load handled by the key store port, unused code ignored
                        end
                    endcase
                end
            end
            ST_FILL: begin
                // identity permutation
                perm_we    = 1'b1;
                perm_waddr = n_reg;
                perm_wdata = n_reg;
                n_next     = n_reg + 8'd1;
                if (n_reg == 8'hFF) begin
                    j_next     = '0;
                    kn_next    = '0;
                    state_next = ST_KRDN;
                end
            end
            ST_KRDN: begin
                perm_raddr = n_reg;
                state_next = ST_KRDJ;
            end
            ST_KRDJ: begin
                si_next    = perm_rdata;
                j_next     = j_reg + perm_rdata + key_rdata;
                perm_raddr = j_reg + perm_rdata + key_rdata;
                state_next = ST_KWRN;
            end
            ST_KWRN: begin
                perm_we    = 1'b1;
                perm_waddr = n_reg;
                perm_wdata = perm_rdata;
                state_next = ST_KWRJ;
            end
            ST_KWRJ: begin
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = si_reg;
                n_next     = n_reg + 8'd1;
                if ((KLEN_W'(kn_reg) + KLEN_W'(1)) == eff_len) begin
                    kn_next = '0;
                end else begin
                    kn_next = kn_reg + KEY_AW'(1);
                end
                if (n_reg == 8'hFF) begin
                    i_next     = '0;
                    j_next     = '0;
                    keyed_next = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_KRDN;
                end
            end
            ST_CRDJ: begin
                si_next    = perm_rdata;
                j_next     = j_reg + perm_rdata;
                perm_raddr = j_reg + perm_rdata;
                state_next = ST_CSWP;
            end
            ST_CSWP: begin
                // S[i] takes S[j], fetch S[t]
                sj_next    = perm_rdata;
                perm_we    = 1'b1;
                perm_waddr = i_reg;
                perm_wdata = perm_rdata;
                t_next     = si_reg + perm_rdata;
                perm_raddr = si_reg + perm_rdata;
                state_next = ST_CEMIT;
            end
            ST_CEMIT: begin
                // S[j] takes old S[i]; repeated harmlessly while the output stalls
                perm_we    = !nk_reg;
                perm_waddr = j_reg;
                perm_wdata = si_reg;
                perm_raddr = t_reg;
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_nk_next     = nk_reg;
                    m_data_next   = nk_reg ? data_reg : (data_reg ^ ks);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            key_length_reg <= KLEN_RESET;
            i_reg          <= '0;
            j_reg          <= '0;
            keyed_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            keyed_reg    <= keyed_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                key_length_reg <= cfg_data;
            end
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        kn_reg     <= kn_next;
        si_reg     <= si_next;
        sj_reg     <= sj_next;
        t_reg      <= t_next;
        data_reg   <= data_next;
        nk_reg     <= nk_next;
        m_data_reg <= m_data_next;
        m_nk_reg   <= m_nk_next;
    end

    // permutation table
    rc4_ram #(
        .DEPTH(PERM_DEPTH),
        .AW   (PERM_AW)
    ) u_perm_ram (
        .aclk   (aclk),
        .wr_en  (perm_we),
        .wr_addr(perm_waddr),
        .wr_data(perm_wdata),
        .rd_addr(perm_raddr),
        .rd_data(perm_rdata)
    );

    // key store
    rc4_ram #(
        .DEPTH(KEY_BYTES),
        .AW   (KEY_AW)
    ) u_key_ram (
        .aclk   (aclk),
        .wr_en  (key_we),
        .wr_addr(key_waddr),
        .wr_data(in_data),
        .rd_addr(key_raddr),
        .rd_data(key_rdata)
    );

    // a keyed crypt only reaches the output stage once scheduled
    a_keyed_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CEMIT && !nk_reg) |-> keyed_reg)
        else $error("keyed crypt emitted while not keyed");

    // the last schedule step leaves cleared indices and the keyed flag
    a_sched_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_KWRJ && n_reg == 8'hFF) |=>
        (i_reg == 8'd0 && j_reg == 8'd0 && keyed_reg && state_reg == ST_IDLE))
        else $error("schedule finished with bad index state");

    // key counter stays below the effective key length
    a_key_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_KRDN) |-> (KLEN_W'(kn_reg) < eff_len))
        else $error("key counter beyond key length");

    // a new result only comes from the emit state
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_CEMIT))
        else $error("result loaded outside emit state");

endmodule

### sv/rc4_ram.sv
`timescale 1ns / 1ps
// byte-wide synchronous ram, one write port and one registered read port
// depends on rc4_pkg for the byte type
module rc4_ram #(
    parameter int DEPTH = 256,
    parameter int AW = 8
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  rc4_pkg::byte_t wr_data,
    input  logic [AW-1:0] rd_addr,
    output rc4_pkg::byte_t rd_data
);
    import rc4_pkg::*;

    byte_t mem [DEPTH];
    byte_t rd_data_reg;

    // write port and read-first registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
